@@ src/mavg_pkg.sv @@
// Shared constants, state encoding and control structs for the moving average block.
package mavg_pkg;

    localparam int WINDOW_MAX  = 1024;
    localparam int PTR_W       = $clog2(WINDOW_MAX);
    localparam int LEN_W       = PTR_W + 1;
    localparam int SAMPLE_BITS = 32;
    localparam int ENTRY_W     = SAMPLE_BITS + 1;
    localparam int SUM_W       = SAMPLE_BITS + PTR_W;
    localparam int DIV_STEPS   = SUM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_RETIRE,
        ST_DIV_LOAD,
        ST_DIV_WAIT,
        ST_EMIT
    } mavg_state_t;

    typedef struct packed {
        logic accept;
        logic read;
        logic retire;
        logic div_start;
        logic emit;
    } mavg_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } mavg_status_t;

endpackage

@@ src/moving_average_nan_aware.sv @@
// Top level of the missing-aware boxcar moving average.
// Each accepted word yields one result word: the sum of the present samples among the
// last N words, divided by the full N with truncation toward zero, where N is the
// configured window length (0 acts as 1, above 1024 acts as 1024). Missing samples add
// nothing; the result is flagged missing, with a zero value, when every sample in the
// window is missing. A series start on a word, or any write of the window length, empties
// the window. Each word passes in order through the window memory read with the sum and
// count updates, the divider, which produces one quotient bit per cycle over the 42-bit
// sum, and the hand-off to the output register; only then can the next word be taken.
// The output register lets the next word be accepted while a result still waits on
// m_tready.
module moving_average_nan_aware (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mavg_pkg::SAMPLE_BITS-1:0]  s_tdata,     // sample_value
    input  logic [1:0]                        s_tuser,     // sample_missing, series_start
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mavg_pkg::SAMPLE_BITS-1:0]  m_tdata,     // mean_value
    output logic                              m_tuser,     // mean_missing
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [mavg_pkg::LEN_W-1:0]        cfg_wr_data
);
    import mavg_pkg::*;

    mavg_cmd_t    cmd;
    mavg_status_t status;

    mavg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mavg_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

@@ src/mavg_div.sv @@
// Bit-serial restoring divider: signed sum divided by the unsigned window length.
module mavg_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [mavg_pkg::SUM_W-1:0]  dividend,
    input  logic [mavg_pkg::LEN_W-1:0]  divisor,
    output logic                        busy,
    output logic [mavg_pkg::SAMPLE_BITS-1:0] quotient
);
    import mavg_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic [LEN_W-1:0]     rem_reg, rem_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [LEN_W:0]       trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            neg_next  = dividend[SUM_W-1];
            rem_next  = '0;
            // The magnitude of the most negative sum still fits as unsigned.
            quo_next  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
        end else if (busy_reg) begin
            rem_next = fits ? LEN_W'(trial - {1'b0, divisor}) : trial[LEN_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? (~quo_reg[SAMPLE_BITS-1:0] + 1'b1) : quo_reg[SAMPLE_BITS-1:0];

endmodule

@@ src/mavg_ctrl.sv @@
// Controller state machine that sequences one word through the datapath.
module mavg_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  mavg_pkg::mavg_status_t status,
    output mavg_pkg::mavg_cmd_t    cmd
);
    import mavg_pkg::*;

    mavg_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:     state_next = ST_RETIRE;
            ST_RETIRE:   state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_READ:     cmd.read      = 1'b1;
            ST_RETIRE:   cmd.retire    = 1'b1;
            ST_DIV_LOAD: cmd.div_start = 1'b1;
            ST_DIV_WAIT: cmd           = '0;
            ST_EMIT:     cmd.emit      = status.out_free;
            default:     cmd           = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ src/mavg_dp.sv @@
// Datapath: window memory, running sum and counts, divider and output register.
module mavg_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mavg_pkg::mavg_cmd_t               cmd,
    output mavg_pkg::mavg_status_t            status,
    input  logic [mavg_pkg::SAMPLE_BITS-1:0]  s_tdata,
    input  logic [1:0]                        s_tuser,
    input  logic                              s_tlast,
    input  logic                              cfg_wr_en,
    input  logic [mavg_pkg::LEN_W-1:0]        cfg_wr_data,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [mavg_pkg::SAMPLE_BITS-1:0]  m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import mavg_pkg::*;

    logic [ENTRY_W-1:0] mem [WINDOW_MAX];

    logic [LEN_W-1:0]       len_reg, len_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [LEN_W-1:0]       miss_cnt_reg, miss_cnt_next;
    logic [LEN_W-1:0]       fill_cnt_reg, fill_cnt_next;
    logic [PTR_W-1:0]       wp_reg, wp_next;
    logic                   retire_reg, retire_next;
    logic [SAMPLE_BITS-1:0] in_val_reg;
    logic                   in_miss_reg;
    logic                   in_end_reg;
    logic [ENTRY_W-1:0]     old_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [SAMPLE_BITS-1:0] m_data_reg;
    logic                   m_miss_reg;
    logic                   m_last_reg;

    logic [LEN_W-1:0]       wp_inc;
    logic [LEN_W-1:0]       miss_dec;
    logic                   all_missing;
    logic                   div_busy;
    logic [SAMPLE_BITS-1:0] quotient;

    assign wp_inc      = {1'b0, wp_reg} + 1'b1;
    assign all_missing = miss_cnt_reg == fill_cnt_reg;

    always_comb begin
        miss_dec = miss_cnt_reg;
        if (retire_reg && old_reg[SAMPLE_BITS] && (miss_cnt_reg != '0)) begin
            miss_dec = miss_cnt_reg - 1'b1;
        end
    end

    always_comb begin
        len_next      = len_reg;
        sum_next      = sum_reg;
        miss_cnt_next = miss_cnt_reg;
        fill_cnt_next = fill_cnt_reg;
        wp_next       = wp_reg;
        retire_next   = retire_reg;
        if (cfg_wr_en) begin
            // A new length restarts the series.
            if (cfg_wr_data == '0) begin
                len_next = LEN_W'(1);
            end else if (cfg_wr_data > LEN_W'(WINDOW_MAX)) begin
                len_next = LEN_W'(WINDOW_MAX);
            end else begin
                len_next = cfg_wr_data;
            end
            sum_next      = '0;
            miss_cnt_next = '0;
            fill_cnt_next = '0;
            wp_next       = '0;
        end else if (cmd.accept) begin
            if (s_tuser[1]) begin
                sum_next      = '0;
                miss_cnt_next = '0;
                fill_cnt_next = '0;
                wp_next       = '0;
            end else if ({1'b0, wp_reg} >= len_reg) begin
                wp_next = '0;
            end
        end else if (cmd.read) begin
            if (!in_miss_reg) begin
                sum_next = sum_reg + {{(SUM_W-SAMPLE_BITS){in_val_reg[SAMPLE_BITS-1]}},
                                      in_val_reg};
            end
            retire_next = fill_cnt_reg >= len_reg;
            if (fill_cnt_reg >= len_reg) begin
                fill_cnt_next = len_reg;
            end else begin
                fill_cnt_next = fill_cnt_reg + 1'b1;
            end
        end else if (cmd.retire) begin
            if (retire_reg && !old_reg[SAMPLE_BITS]) begin
                sum_next = sum_reg - {{(SUM_W-SAMPLE_BITS){old_reg[SAMPLE_BITS-1]}},
                                      old_reg[SAMPLE_BITS-1:0]};
            end
            miss_cnt_next = miss_dec + LEN_W'(in_miss_reg);
            wp_next       = (wp_inc >= len_reg) ? '0 : wp_inc[PTR_W-1:0];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= LEN_W'(1);
            sum_reg      <= '0;
            miss_cnt_reg <= '0;
            fill_cnt_reg <= '0;
            wp_reg       <= '0;
            retire_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            len_reg      <= len_next;
            sum_reg      <= sum_next;
            miss_cnt_reg <= miss_cnt_next;
            fill_cnt_reg <= fill_cnt_next;
            wp_reg       <= wp_next;
            retire_reg   <= retire_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_val_reg  <= s_tdata;
            in_miss_reg <= s_tuser[0];
            in_end_reg  <= s_tlast;
        end
        if (cmd.emit) begin
            m_data_reg <= all_missing ? '0 : quotient;
            m_miss_reg <= all_missing;
            m_last_reg <= in_end_reg;
        end
    end

    // Window memory: the oldest word is read in the cycle before the new one lands there.
    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            old_reg <= mem[wp_reg];
        end
        if (cmd.retire) begin
            mem[wp_reg] <= in_miss_reg ? {1'b1, {SAMPLE_BITS{1'b0}}} : {1'b0, in_val_reg};
        end
    end

    mavg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (sum_reg),
        .divisor  (len_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign status = '{div_done: !div_busy, out_free: !m_valid_reg || m_tready};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_miss_reg;
    assign m_tlast  = m_last_reg;

endmodule
